// ----- rtl/vkd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vkd_pkg
// Shared types, sizes and helpers for the vertex key deduplication table.
// ----------------------------------------------------------------------------
package vkd_pkg;

    localparam int FIELD_BITS  = 20;
    localparam int INDEX_BITS  = 20;
    localparam int ADDR_BITS   = 12;
    localparam int TABLE_DEPTH = 2 ** ADDR_BITS;
    localparam int KEY_BITS    = 3 * INDEX_BITS;
    localparam int NUMBER_BITS = 12;
    localparam int COUNT_BITS  = NUMBER_BITS + 1;
    localparam int NUMBER_LIMIT = 2 ** NUMBER_BITS;
    localparam int IDX_WIDE  = (INDEX_BITS > FIELD_BITS) ? INDEX_BITS : FIELD_BITS;
    localparam int HASH_WIDE = (INDEX_BITS > ADDR_BITS) ? INDEX_BITS : ADDR_BITS;

    typedef enum logic [1:0] {
        STAT_REUSED  = 2'd0,
        STAT_NEW     = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_CLEARED = 2'd3
    } t_status;

    typedef struct packed {
        logic                  mode;
        logic [FIELD_BITS-1:0] position_index;
        logic [FIELD_BITS-1:0] texcoord_index;
        logic [FIELD_BITS-1:0] normal_index;
    } t_in_word;

    typedef struct packed {
        logic [NUMBER_BITS-1:0] vertex_number;
        t_status                status;
    } t_out_word;

    // one table slot as stored in the memory
    typedef struct packed {
        logic                   valid;
        logic [KEY_BITS-1:0]    key;
        logic [NUMBER_BITS-1:0] number;
    } t_slot;

    typedef struct packed {
        logic                 wr_en;
        logic [ADDR_BITS-1:0] wr_addr;
        t_slot                wr_data;
        logic [ADDR_BITS-1:0] rd_addr;
    } t_ram_req;

    function automatic logic [INDEX_BITS-1:0] f_idx(input logic [FIELD_BITS-1:0] v);
        logic [IDX_WIDE-1:0] w;
        w = IDX_WIDE'(v);
        return w[INDEX_BITS-1:0];
    endfunction

    function automatic logic [ADDR_BITS-1:0] f_home(input logic [INDEX_BITS-1:0] p,
                                                    input logic [INDEX_BITS-1:0] t,
                                                    input logic [INDEX_BITS-1:0] n);
        logic [HASH_WIDE-1:0] h;
        h = HASH_WIDE'(p ^ t ^ n);
        return h[ADDR_BITS-1:0];
    endfunction

endpackage

// ----- rtl/vkd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vkd_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module vkd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/vkd_probe.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vkd_probe
// Probe sequencer: hashes the key, walks the table by linear probing, inserts
// new keys, and sweeps the table clear after reset and on a clear word.
// ----------------------------------------------------------------------------
module vkd_probe import vkd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_word  i_in_word,
    output logic      o_in_stall,
    output t_ram_req  o_ram,
    input  t_slot     i_rd_slot,
    output logic      o_res_valid,
    output t_out_word o_res_word,
    input  logic      i_res_ready
);

    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_PROBE,
        S_RESULT
    } t_state;

    t_state                 r_state,      n_state;
    logic [KEY_BITS-1:0]    r_key,        n_key;
    logic [ADDR_BITS-1:0]   r_rd_addr,    n_rd_addr;
    logic [ADDR_BITS-1:0]   r_probes,     n_probes;
    logic [ADDR_BITS-1:0]   r_sweep_addr, n_sweep_addr;
    logic [COUNT_BITS-1:0]  r_count,      n_count;
    logic                   r_clr,        n_clr;
    t_out_word              r_res,        n_res;

    logic [INDEX_BITS-1:0]  in_p, in_t, in_n;
    logic [KEY_BITS-1:0]    in_key;
    logic [ADDR_BITS-1:0]   in_home;
    logic                   accept;

    assign in_p    = f_idx(i_in_word.position_index);
    assign in_t    = f_idx(i_in_word.texcoord_index);
    assign in_n    = f_idx(i_in_word.normal_index);
    assign in_key  = {in_n, in_t, in_p};
    assign in_home = f_home(in_p, in_t, in_n);
    assign accept  = (r_state == S_IDLE) && i_in_valid;

    always_comb begin
        n_state      = r_state;
        n_key        = r_key;
        n_rd_addr    = r_rd_addr;
        n_probes     = r_probes;
        n_sweep_addr = r_sweep_addr;
        n_count      = r_count;
        n_clr        = r_clr;
        n_res        = r_res;

        o_ram.wr_en   = 1'b0;
        o_ram.wr_addr = r_rd_addr;
        o_ram.wr_data = '0;
        // in probe, fetch the following slot ahead; it is dropped if unused
        o_ram.rd_addr = (r_state == S_PROBE) ? r_rd_addr + 1'b1 : in_home;

        unique case (r_state)
            S_SWEEP: begin
                o_ram.wr_en   = 1'b1;
                o_ram.wr_addr = r_sweep_addr;
                n_sweep_addr  = r_sweep_addr + 1'b1;
                if (r_sweep_addr == '1) begin
                    n_count = '0;
                    n_res.vertex_number = '0;
                    n_res.status        = STAT_CLEARED;
                    n_state = r_clr ? S_RESULT : S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_in_word.mode) begin
                        n_sweep_addr = '0;
                        n_clr        = 1'b1;
                        n_state      = S_SWEEP;
                    end else begin
                        n_key     = in_key;
                        n_rd_addr = in_home;
                        n_probes  = '0;
                        n_state   = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                priority if (!i_rd_slot.valid) begin
                    n_state = S_RESULT;
                    if (r_count >= COUNT_BITS'(NUMBER_LIMIT)) begin
                        n_res.vertex_number = '0;
                        n_res.status        = STAT_FULL;
                    end else begin
                        o_ram.wr_en          = 1'b1;
                        o_ram.wr_data.valid  = 1'b1;
                        o_ram.wr_data.key    = r_key;
                        o_ram.wr_data.number = r_count[NUMBER_BITS-1:0];
                        n_res.vertex_number  = r_count[NUMBER_BITS-1:0];
                        n_res.status         = STAT_NEW;
                        n_count              = r_count + 1'b1;
                    end
                end else if (i_rd_slot.key == r_key) begin
                    n_state = S_RESULT;
                    n_res.vertex_number = i_rd_slot.number;
                    n_res.status        = STAT_REUSED;
                end else if (r_probes == '1) begin
                    // every slot visited, none free
                    n_state = S_RESULT;
                    n_res.vertex_number = '0;
                    n_res.status        = STAT_FULL;
                end else begin
                    n_probes  = r_probes + 1'b1;
                    n_rd_addr = r_rd_addr + 1'b1;
                end
            end
            S_RESULT: begin
                if (i_res_ready) begin
                    n_clr   = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_SWEEP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;
            r_sweep_addr <= '0;
            r_count      <= '0;
            r_clr        <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sweep_addr <= n_sweep_addr;
            r_count      <= n_count;
            r_clr        <= n_clr;
        end
        r_key     <= n_key;
        r_rd_addr <= n_rd_addr;
        r_probes  <= n_probes;
        r_res     <= n_res;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_RESULT);
    assign o_res_word  = r_res;

endmodule

// ----- rtl/vkd_out.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vkd_out
// Output register: holds one result word for the receiver.
// ----------------------------------------------------------------------------
module vkd_out import vkd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_res_valid,
    input  t_out_word i_res_word,
    output logic      o_res_ready,
    output logic      o_out_valid,
    output t_out_word o_out_word,
    input  logic      i_out_stall
);

    logic      r_valid, n_valid;
    t_out_word r_word;
    logic      load;

    assign o_res_ready = !r_valid || !i_out_stall;
    assign load        = i_res_valid && o_res_ready;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= i_res_word;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_word  = r_word;

endmodule

// ----- rtl/vertex_key_dedup_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_key_dedup_table
// Maps face-corner key triples to dense vertex numbers by a probed hash table.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall / i_in_word): one word per face
// corner, or a clear word (mode set). Output channel (o_out_valid /
// i_out_stall / o_out_word): one result word per input word, in order.
// A lookup hashes the three indices to a home slot and reads one slot per
// cycle from the slot memory, moving linearly until it hits the key or a
// free slot or has visited every slot. The number of slots visited is one
// at low table load and grows with clustering, up to TABLE_DEPTH; no new
// word is accepted until the last result has left the probe sequencer.
// A clear word sweeps the memory, one slot per cycle, then returns
// status cleared.
// After reset the same sweep runs with o_in_stall high; the vertex count
// restarts at zero.
// The output register parts the two sides: the next word is accepted while
// a result waits; if the receiver stalls, a second result waits inside and
// input stays stalled until the register drains.
// ----------------------------------------------------------------------------
module vertex_key_dedup_table import vkd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_word  i_in_word,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_word o_out_word,
    input  logic      i_out_stall
);

    t_ram_req  ram_req;
    t_slot     rd_slot;
    logic      res_valid;
    t_out_word res_word;
    logic      res_ready;

    vkd_probe u_probe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .o_ram       (ram_req),
        .i_rd_slot   (rd_slot),
        .o_res_valid (res_valid),
        .o_res_word  (res_word),
        .i_res_ready (res_ready)
    );

    vkd_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_req.wr_en),
        .i_wr_addr (ram_req.wr_addr),
        .i_wr_data (ram_req.wr_data),
        .i_rd_addr (ram_req.rd_addr),
        .o_rd_data (rd_slot)
    );

    vkd_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res_word  (res_word),
        .o_res_ready (res_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

endmodule

// ----- rtl/vkd_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vkd_check
// Port-level checks for the vertex key deduplication table.
// ----------------------------------------------------------------------------
module vkd_check import vkd_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input t_in_word  i_in_word,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input t_out_word o_out_word,
    input logic      i_out_stall
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed under stall");

    // the table is swept after reset before any word is taken
    a_sweep_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input taken during reset sweep");

    // one word at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second word accepted back to back");

    // full and cleared results carry number zero
    a_zero_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status == STAT_FULL ||
                        o_out_word.status == STAT_CLEARED)
        |-> o_out_word.vertex_number == '0)
        else $error("nonzero number on full or cleared result");

    // a clear word leaves input stalled once its sweep has begun
    a_clear_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_word.mode |=> ##1 o_in_stall)
        else $error("input taken during clear sweep");

endmodule

bind vertex_key_dedup_table vkd_check u_vkd_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_word   (i_in_word),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_word  (o_out_word),
    .i_out_stall (i_out_stall)
);
